/* rtl/tld_pkg.sv */
// Shared types and constants for the tree ancestor and distance engine.
package tld_pkg;

  localparam int NODE_W   = 10;
  localparam int WEIGHT_W = 20;
  localparam int DEPTH_W  = 11;
  localparam int DIST_W   = 30;
  localparam int HOP_W    = 11;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [HOP_W-1:0]   HOP_MAX   = '1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [DIST_W-1:0]  rdist;
  } info_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_INFO,
    S_LD_RD,
    S_LD_WR,
    S_Q_INFO,
    S_Q_LIFT,
    S_Q_LIFT_W,
    S_Q_MEET,
    S_Q_CLIMB,
    S_Q_CLIMB_W,
    S_Q_TOP,
    S_Q_TOP_W,
    S_Q_DONE
  } tld_state_t;

endpackage

/* rtl/tld_if.sv */
// Valid/ready channel interfaces for load/query items and result items.
interface tld_in_if import tld_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [NODE_W-1:0]   node;
  logic [NODE_W-1:0]   parent;
  logic [WEIGHT_W-1:0] edge_weight;
  logic [NODE_W-1:0]   query_a;
  logic [NODE_W-1:0]   query_b;

  modport source (output valid, action, node, parent, edge_weight, query_a, query_b,
                  input ready);
  modport sink (input valid, action, node, parent, edge_weight, query_a, query_b,
                output ready);
endinterface

interface tld_out_if import tld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] common_ancestor;
  logic [HOP_W-1:0]  hop_distance;
  logic [DIST_W-1:0] weighted_distance;

  modport source (output valid, common_ancestor, hop_distance, weighted_distance,
                  input ready);
  modport sink (input valid, common_ancestor, hop_distance, weighted_distance,
                output ready);
endinterface

/* rtl/tree_lca_distance_engine_top.sv */
// Binary-lifting lowest common ancestor and path distance engine, top level.
//
// A load item (action 0) stores a node's depth, root distance and its power-of-two
// ancestors and gives no result; level zero is written with the parent, and each
// higher ancestor level is one read of the ancestor memory followed by one
// write. A query item (action 1) returns the lowest common ancestor, hop count and
// weighted distance of two nodes; its time is set by the chain of dependent
// ancestor memory reads: one read per set bit of the depth gap while lifting to
// equal depth, and one read of each node's ancestor per level while climbing
// both nodes together. The result sits in an output register, so
// the next item is accepted while a result still waits. Parents must be loaded
// before their children; node 0 is the sentinel above the root and reads as zero.
// Memory contents need no clearing after reset.
module tree_lca_distance_engine_top import tld_pkg::*; #(
  parameter int NODE_COUNT  = 1024,
  parameter int LIFT_LEVELS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  tld_in_if.sink    in_ch,
  tld_out_if.source out_ch
);

  localparam int AW        = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
  localparam int LW        = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int AAW       = AW + LW;
  localparam int ANC_DEPTH = NODE_COUNT * (2 ** LW);
  localparam logic [LW-1:0] LAST_LVL = LW'(LIFT_LEVELS - 1);
  localparam logic [16:0]   NODE_LIM = 17'(NODE_COUNT);

  function automatic logic [AW-1:0] to_addr(input logic [NODE_W-1:0] n);
    logic [AW+NODE_W-1:0] t;
    t = {{AW{1'b0}}, n};
    return t[AW-1:0];
  endfunction

  function automatic logic in_range(input logic [NODE_W-1:0] n);
    return ({7'd0, n} < NODE_LIM);
  endfunction

  // Memories
  logic [NODE_W-1:0] anc_mem [ANC_DEPTH];
  info_t             info_mem [NODE_COUNT];

  logic              anc_re_a, anc_re_b, anc_we;
  logic [AAW-1:0]    anc_ra_a, anc_ra_b, anc_wa;
  logic [NODE_W-1:0] anc_wd;
  logic [NODE_W-1:0] anc_qa_raw_r, anc_qb_raw_r;
  logic              anc_qa_zero_r, anc_qb_zero_r;
  logic [NODE_W-1:0] anc_qa, anc_qb;

  logic              info_re_a, info_re_b, info_we;
  logic [AW-1:0]     info_ra_a, info_ra_b, info_wa;
  info_t             info_wd;
  info_t             info_qa_raw_r, info_qb_raw_r;
  logic              info_qa_zero_r, info_qb_zero_r;
  info_t             info_qa, info_qb;

  always_ff @(posedge clk) begin
    if (anc_we) begin
      anc_mem[anc_wa] <= anc_wd;
    end
    if (anc_re_a) begin
      anc_qa_raw_r  <= anc_mem[anc_ra_a];
      anc_qa_zero_r <= (anc_ra_a[AAW-1:LW] == '0);
    end
    if (anc_re_b) begin
      anc_qb_raw_r  <= anc_mem[anc_ra_b];
      anc_qb_zero_r <= (anc_ra_b[AAW-1:LW] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      info_mem[info_wa] <= info_wd;
    end
    if (info_re_a) begin
      info_qa_raw_r  <= info_mem[info_ra_a];
      info_qa_zero_r <= (info_ra_a == '0);
    end
    if (info_re_b) begin
      info_qb_raw_r  <= info_mem[info_ra_b];
      info_qb_zero_r <= (info_ra_b == '0);
    end
  end

  assign anc_qa  = anc_qa_zero_r  ? '0 : anc_qa_raw_r;
  assign anc_qb  = anc_qb_zero_r  ? '0 : anc_qb_raw_r;
  assign info_qa = info_qa_zero_r ? '0 : info_qa_raw_r;
  assign info_qb = info_qb_zero_r ? '0 : info_qb_raw_r;

  // Control and working registers
  tld_state_t           state_r, state_nxt;
  logic [AW-1:0]        x_r, x_nxt;
  logic [WEIGHT_W-1:0]  w_r, w_nxt;
  logic [NODE_W-1:0]    u_r, u_nxt;
  logic [NODE_W-1:0]    v_r, v_nxt;
  logic [NODE_W-1:0]    c_r, c_nxt;
  logic [LW-1:0]        lvl_r, lvl_nxt;
  logic [LIFT_LEVELS-1:0] gap_r, gap_nxt;
  logic [DEPTH_W-1:0]   da_r, da_nxt, db_r, db_nxt;
  logic [DIST_W-1:0]    ra_r, ra_nxt, rb_r, rb_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]    out_ca_r, out_ca_nxt;
  logic [HOP_W-1:0]     out_hop_r, out_hop_nxt;
  logic [DIST_W-1:0]    out_wd_r, out_wd_nxt;

  logic [NODE_W-1:0]    p_clip, a_clip, b_clip;
  logic                 load_ok;
  logic [DEPTH_W:0]     new_depth;
  logic [DIST_W:0]      new_dist;
  logic [DEPTH_W-1:0]   depth_gap;
  logic [DEPTH_W+LIFT_LEVELS-1:0] gap_ext;
  logic [DEPTH_W:0]     hop_sum, hop_sub, hop_diff;
  logic [DIST_W:0]      wd_sum, wd_sub, wd_diff;

  assign p_clip  = in_range(in_ch.parent)  ? in_ch.parent  : '0;
  assign a_clip  = in_range(in_ch.query_a) ? in_ch.query_a : '0;
  assign b_clip  = in_range(in_ch.query_b) ? in_ch.query_b : '0;
  assign load_ok = (in_ch.node != '0) && in_range(in_ch.node);

  assign new_depth = {1'b0, info_qa.depth} + (DEPTH_W+1)'(1);
  assign new_dist  = {1'b0, info_qa.rdist} + (DIST_W+1)'(w_r);

  assign depth_gap = (info_qa.depth < info_qb.depth) ? info_qb.depth - info_qa.depth
                                                     : info_qa.depth - info_qb.depth;
  assign gap_ext   = {{LIFT_LEVELS{1'b0}}, depth_gap};

  assign hop_sum  = {1'b0, da_r} + {1'b0, db_r};
  assign hop_sub  = {info_qa.depth, 1'b0};
  assign hop_diff = hop_sum - hop_sub;
  assign wd_sum   = {1'b0, ra_r} + {1'b0, rb_r};
  assign wd_sub   = {info_qa.rdist, 1'b0};
  assign wd_diff  = wd_sum - wd_sub;

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    w_nxt         = w_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    c_nxt         = c_r;
    lvl_nxt       = lvl_r;
    gap_nxt       = gap_r;
    da_nxt        = da_r;
    db_nxt        = db_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ca_nxt    = out_ca_r;
    out_hop_nxt   = out_hop_r;
    out_wd_nxt    = out_wd_r;

    anc_re_a  = 1'b0;
    anc_re_b  = 1'b0;
    anc_we    = 1'b0;
    anc_ra_a  = {to_addr(u_r), lvl_r};
    anc_ra_b  = {to_addr(v_r), lvl_r};
    anc_wa    = {x_r, lvl_r};
    anc_wd    = anc_qa;
    info_re_a = 1'b0;
    info_re_b = 1'b0;
    info_we   = 1'b0;
    info_ra_a = to_addr(u_r);
    info_ra_b = to_addr(v_r);
    info_wa   = x_r;
    info_wd.depth = new_depth[DEPTH_W] ? DEPTH_MAX : new_depth[DEPTH_W-1:0];
    info_wd.rdist = new_dist[DIST_W]   ? DIST_MAX  : new_dist[DIST_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.action == ACT_LOAD) begin
            if (load_ok) begin
              x_nxt     = to_addr(in_ch.node);
              u_nxt     = p_clip;
              w_nxt     = in_ch.edge_weight;
              info_re_a = 1'b1;
              info_ra_a = to_addr(p_clip);
              state_nxt = S_LD_INFO;
            end
          end else begin
            u_nxt     = a_clip;
            v_nxt     = b_clip;
            info_re_a = 1'b1;
            info_ra_a = to_addr(a_clip);
            info_re_b = 1'b1;
            info_ra_b = to_addr(b_clip);
            state_nxt = S_Q_INFO;
          end
        end
      end
      S_LD_INFO: begin
        info_we   = 1'b1;
        anc_we    = 1'b1;
        anc_wa    = {x_r, LW'(0)};
        anc_wd    = u_r;
        lvl_nxt   = LW'(1);
        state_nxt = (LIFT_LEVELS == 1) ? S_IDLE : S_LD_RD;
      end
      S_LD_RD: begin
        anc_re_a  = 1'b1;
        anc_ra_a  = {to_addr(u_r), LW'(lvl_r - LW'(1))};
        state_nxt = S_LD_WR;
      end
      S_LD_WR: begin
        anc_we = 1'b1;
        u_nxt  = anc_qa;
        if (lvl_r == LAST_LVL) begin
          state_nxt = S_IDLE;
        end else begin
          lvl_nxt   = LW'(lvl_r + LW'(1));
          state_nxt = S_LD_RD;
        end
      end
      S_Q_INFO: begin
        da_nxt  = info_qa.depth;
        db_nxt  = info_qb.depth;
        ra_nxt  = info_qa.rdist;
        rb_nxt  = info_qb.rdist;
        gap_nxt = gap_ext[LIFT_LEVELS-1:0];
        lvl_nxt = LAST_LVL;
        if (info_qa.depth < info_qb.depth) begin
          u_nxt = v_r;
          v_nxt = u_r;
        end
        state_nxt = S_Q_LIFT;
      end
      S_Q_LIFT: begin
        if (gap_r[lvl_r]) begin
          anc_re_a  = 1'b1;
          state_nxt = S_Q_LIFT_W;
        end else if (lvl_r == '0) begin
          state_nxt = S_Q_MEET;
        end else begin
          lvl_nxt = LW'(lvl_r - LW'(1));
        end
      end
      S_Q_LIFT_W: begin
        u_nxt = anc_qa;
        if (lvl_r == '0) begin
          state_nxt = S_Q_MEET;
        end else begin
          lvl_nxt   = LW'(lvl_r - LW'(1));
          state_nxt = S_Q_LIFT;
        end
      end
      S_Q_MEET: begin
        if (u_r == v_r) begin
          c_nxt     = u_r;
          info_re_a = 1'b1;
          state_nxt = S_Q_DONE;
        end else begin
          lvl_nxt   = LAST_LVL;
          state_nxt = S_Q_CLIMB;
        end
      end
      S_Q_CLIMB: begin
        anc_re_a  = 1'b1;
        anc_re_b  = 1'b1;
        state_nxt = S_Q_CLIMB_W;
      end
      S_Q_CLIMB_W: begin
        if (anc_qa != anc_qb) begin
          u_nxt = anc_qa;
          v_nxt = anc_qb;
        end
        if (lvl_r == '0) begin
          state_nxt = S_Q_TOP;
        end else begin
          lvl_nxt   = LW'(lvl_r - LW'(1));
          state_nxt = S_Q_CLIMB;
        end
      end
      S_Q_TOP: begin
        anc_re_a  = 1'b1;
        anc_ra_a  = {to_addr(u_r), LW'(0)};
        state_nxt = S_Q_TOP_W;
      end
      S_Q_TOP_W: begin
        c_nxt     = anc_qa;
        info_re_a = 1'b1;
        info_ra_a = to_addr(anc_qa);
        state_nxt = S_Q_DONE;
      end
      S_Q_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ca_nxt    = c_r;
          if (hop_sub > hop_sum) begin
            out_hop_nxt = '0;
          end else begin
            out_hop_nxt = hop_diff[DEPTH_W] ? HOP_MAX : hop_diff[HOP_W-1:0];
          end
          if (wd_sub > wd_sum) begin
            out_wd_nxt = '0;
          end else begin
            out_wd_nxt = wd_diff[DIST_W] ? DIST_MAX : wd_diff[DIST_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    w_r       <= w_nxt;
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    c_r       <= c_nxt;
    lvl_r     <= lvl_nxt;
    gap_r     <= gap_nxt;
    da_r      <= da_nxt;
    db_r      <= db_nxt;
    ra_r      <= ra_nxt;
    rb_r      <= rb_nxt;
    out_ca_r  <= out_ca_nxt;
    out_hop_r <= out_hop_nxt;
    out_wd_r  <= out_wd_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.common_ancestor   = out_ca_r;
  assign out_ch.hop_distance      = out_hop_r;
  assign out_ch.weighted_distance = out_wd_r;

endmodule

/* rtl/tld_checker.sv */
// Port-level assertions for the tree ancestor engine and their bind to the top level.
module tld_checker import tld_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_action,
  input logic              out_valid,
  input logic              out_ready,
  input logic [NODE_W-1:0] out_common_ancestor,
  input logic [HOP_W-1:0]  out_hop_distance,
  input logic [DIST_W-1:0] out_weighted_distance
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_common_ancestor)
      && $stable(out_hop_distance) && $stable(out_weighted_distance))
    else $error("result item dropped or changed while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_QUERY) |=> !in_ready)
    else $error("input still ready right after a query item");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result item appeared while engine was idle");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_LOAD) |=> !$rose(out_valid))
    else $error("load item produced a result item");

endmodule

bind tree_lca_distance_engine_top tld_checker u_tld_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_ch.valid),
  .in_ready              (in_ch.ready),
  .in_action             (in_ch.action),
  .out_valid             (out_ch.valid),
  .out_ready             (out_ch.ready),
  .out_common_ancestor   (out_ch.common_ancestor),
  .out_hop_distance      (out_ch.hop_distance),
  .out_weighted_distance (out_ch.weighted_distance)
);
